### src/multi_pattern_byte_matcher_unit_defines.svh
// ----------------------------------------------------------------------------
// multi pattern byte matcher assertion macros
// implication checks, switched off for synthesis builds
// ----------------------------------------------------------------------------
`ifndef MULTI_PATTERN_BYTE_MATCHER_UNIT_DEFINES_SVH
`define MULTI_PATTERN_BYTE_MATCHER_UNIT_DEFINES_SVH

`ifndef SYNTH
`define MPBM_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mpbm assertion failed");
`define MPBM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mpbm assertion failed");
`else
`define MPBM_ASSERT_IMPL(label, clk, rst, ante, cons)
`define MPBM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### src/mpbm_pkg.sv
// ----------------------------------------------------------------------------
// mpbm_pkg
// shared codes and defaults of the multi pattern byte matcher
// ----------------------------------------------------------------------------
package mpbm_pkg;

  localparam int DEF_MAX_STATES      = 256;
  localparam int DEF_MAX_PATTERN_LEN = 64;
  localparam int DEF_POSITION_BITS   = 32;

  localparam int MAX_RES = 64;

  localparam logic [8:0] NO_PAT   = 9'd256;
  localparam logic [6:0] REJECTED = 7'd127;

  typedef enum logic [2:0] {
    ACT_CLEAR   = 3'd0,
    ACT_INSERT  = 3'd1,
    ACT_BUILD   = 3'd2,
    ACT_RESTART = 3'd3,
    ACT_SCAN    = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_NO_STATES = 2'd1,
    STS_TOO_LONG  = 2'd2,
    STS_PHASE     = 2'd3
  } status_t;

endpackage

### src/multi_pattern_byte_matcher_unit.sv
// ----------------------------------------------------------------------------
// multi_pattern_byte_matcher_unit
// aho-corasick byte matcher: trie insert, breadth-first build, text scan
// ----------------------------------------------------------------------------
// timing: an insert that makes a new state first sweeps its 256-entry goto
//   row; build walks the root row, then the row of each queued state; any
//   item can be held further by an output stall
// throughput: one item at a time; the next item is taken once the last
//   result is in the output register
// reset: sweeps the root goto row, item_ready low meanwhile
`include "multi_pattern_byte_matcher_unit_defines.svh"

module multi_pattern_byte_matcher_unit
  import mpbm_pkg::*;
#(
  parameter int MAX_STATES      = DEF_MAX_STATES,
  parameter int MAX_PATTERN_LEN = DEF_MAX_PATTERN_LEN,
  parameter int POSITION_BITS   = DEF_POSITION_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [2:0]  action,
  input  logic [7:0]  data_byte,
  input  logic [7:0]  pattern_index,
  input  logic        pattern_end,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [1:0]  status,
  output logic        match_valid,
  output logic [7:0]  match_pattern,
  output logic [31:0] match_end,
  output logic        last_of_run
);

  localparam int IW = $clog2(MAX_STATES);
  localparam int SW = $clog2(MAX_STATES + 1);
  localparam int AW = IW + 8;
  localparam logic [SW-1:0] NONE_ST = SW'(MAX_STATES);

  typedef enum logic [21:0] {
    ST_IDLE      = 22'h000001,
    ST_ROW       = 22'h000002,
    ST_I_RD      = 22'h000004,
    ST_I_CHK     = 22'h000008,
    ST_I_LINK    = 22'h000010,
    ST_I_ADV     = 22'h000020,
    ST_I_END     = 22'h000040,
    ST_I_SO      = 22'h000080,
    ST_B_ROOT_RD = 22'h000100,
    ST_B_ROOT_WR = 22'h000200,
    ST_B_DEQ     = 22'h000400,
    ST_B_Q       = 22'h000800,
    ST_B_F       = 22'h001000,
    ST_B_OL      = 22'h002000,
    ST_B_C_RD    = 22'h004000,
    ST_B_C_WR    = 22'h008000,
    ST_S_G       = 22'h010000,
    ST_S_S       = 22'h020000,
    ST_S_O       = 22'h040000,
    ST_S_RD      = 22'h080000,
    ST_S_M       = 22'h100000,
    ST_DONE      = 22'h200000
  } state_t;

  function automatic logic [IW-1:0] st_ok(input logic [SW-1:0] v);
    return (v < NONE_ST) ? v[IW-1:0] : '0;
  endfunction

  state_t                   state;
  logic [7:0]               cnt;
  logic [IW-1:0]            row;
  logic                     row_ins;
  logic                     emit_after;
  logic [7:0]               b_q;
  logic [7:0]               idx_q;
  logic                     end_q;
  status_t                  st_q;
  logic [IW-1:0]            cursor;
  logic [6:0]               ins_len;
  logic [SW-1:0]            used;
  logic                     built;
  logic [IW-1:0]            scan_state;
  logic [POSITION_BITS-1:0] pos;
  logic [SW-1:0]            head;
  logic [SW-1:0]            tail;
  logic [IW-1:0]            s_q;
  logic [IW-1:0]            f_q;
  logic [SW-1:0]            o_q;
  logic [5:0]               n_q;

  // memories
  logic [SW-1:0] goto_mem [MAX_STATES*256];
  logic [IW-1:0] fail_mem [MAX_STATES];
  logic [8:0]    so_mem   [MAX_STATES];
  logic [SW-1:0] ol_mem   [MAX_STATES];
  logic [IW-1:0] q_mem    [MAX_STATES];

  logic [SW-1:0] ga_d, gb_d, ol_d;
  logic [IW-1:0] fl_d, q_d;
  logic [8:0]    so_d;

  logic [AW-1:0] ga_addr, gb_addr, g_wa;
  logic          g_we;
  logic [SW-1:0] g_wd;
  logic [IW-1:0] fl_addr, fl_wa;
  logic          fl_we;
  logic [IW-1:0] fl_wd;
  logic [IW-1:0] so_addr, so_wa;
  logic          so_we;
  logic [8:0]    so_wd;
  logic [IW-1:0] ol_addr, ol_wa;
  logic          ol_we;
  logic [SW-1:0] ol_wd;
  logic [IW-1:0] q_addr, q_wa;
  logic          q_we;
  logic [IW-1:0] q_wd;

  logic          slot_free;
  logic          res_load;
  logic          enq;
  logic [SW-1:0] o_first;
  logic          m_last;

  assign item_ready = (state == ST_IDLE);
  assign slot_free  = !result_valid || result_ready;
  assign enq        = (ga_d != NONE_ST) && (tail < NONE_ST);
  assign o_first    = (so_d != NO_PAT) ? SW'(s_q) : ol_d;
  assign m_last     = (ol_d >= NONE_ST) || (n_q == 6'(MAX_RES - 1));
  assign res_load   = slot_free && (state == ST_DONE || state == ST_S_M ||
                                    (state == ST_S_O && o_first >= NONE_ST));

  always_comb begin
    ga_addr = '0;
    gb_addr = '0;
    g_we    = 1'b0;
    g_wa    = '0;
    g_wd    = '0;
    fl_addr = '0;
    fl_we   = 1'b0;
    fl_wa   = '0;
    fl_wd   = '0;
    so_addr = '0;
    so_we   = 1'b0;
    so_wa   = '0;
    so_wd   = '0;
    ol_addr = '0;
    ol_we   = 1'b0;
    ol_wa   = '0;
    ol_wd   = '0;
    q_addr  = head[IW-1:0];
    q_we    = 1'b0;
    q_wa    = tail[IW-1:0];
    q_wd    = '0;
    case (state)
      ST_ROW: begin
        g_we  = 1'b1;
        g_wa  = {row, cnt};
        g_wd  = NONE_ST;
        fl_we = 1'b1;
        fl_wa = row;
        so_we = 1'b1;
        so_wa = row;
        so_wd = NO_PAT;
        ol_we = 1'b1;
        ol_wa = row;
        ol_wd = NONE_ST;
      end
      ST_I_RD: ga_addr = {cursor, b_q};
      ST_I_LINK: begin
        g_we = 1'b1;
        g_wa = {cursor, b_q};
        g_wd = SW'(s_q);
      end
      ST_I_END: so_addr = cursor;
      ST_I_SO: begin
        so_addr = cursor;
        so_we   = (so_d == NO_PAT);
        so_wa   = cursor;
        so_wd   = {1'b0, idx_q};
      end
      ST_B_ROOT_RD: ga_addr = {IW'(0), cnt};
      ST_B_ROOT_WR: begin
        if (ga_d == NONE_ST) begin
          g_we = 1'b1;
          g_wa = {IW'(0), cnt};
          g_wd = '0;
        end else begin
          fl_we = 1'b1;
          fl_wa = st_ok(ga_d);
          q_we  = enq;
          q_wd  = st_ok(ga_d);
        end
      end
      ST_B_Q: fl_addr = st_ok(SW'(q_d));
      ST_B_F: begin
        so_addr = fl_d;
        ol_addr = fl_d;
      end
      ST_B_OL: begin
        ol_we = 1'b1;
        ol_wa = s_q;
        ol_wd = (so_d != NO_PAT) ? SW'(f_q) : ol_d;
      end
      ST_B_C_RD: begin
        ga_addr = {s_q, cnt};
        gb_addr = {f_q, cnt};
      end
      ST_B_C_WR: begin
        if (ga_d == NONE_ST) begin
          g_we = 1'b1;
          g_wa = {s_q, cnt};
          g_wd = gb_d;
        end else begin
          fl_we = 1'b1;
          fl_wa = st_ok(ga_d);
          fl_wd = st_ok(gb_d);
          q_we  = enq;
          q_wd  = st_ok(ga_d);
        end
      end
      ST_S_G: ga_addr = {scan_state, b_q};
      ST_S_S: begin
        so_addr = st_ok(ga_d);
        ol_addr = st_ok(ga_d);
      end
      ST_S_O: begin
        so_addr = s_q;
        ol_addr = s_q;
      end
      ST_S_RD, ST_S_M: begin
        so_addr = o_q[IW-1:0];
        ol_addr = o_q[IW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (g_we) begin
      goto_mem[g_wa] <= g_wd;
    end
    ga_d <= goto_mem[ga_addr];
    gb_d <= goto_mem[gb_addr];
  end

  always_ff @(posedge clk) begin
    if (fl_we) begin
      fail_mem[fl_wa] <= fl_wd;
    end
    fl_d <= fail_mem[fl_addr];
  end

  always_ff @(posedge clk) begin
    if (so_we) begin
      so_mem[so_wa] <= so_wd;
    end
    so_d <= so_mem[so_addr];
  end

  always_ff @(posedge clk) begin
    if (ol_we) begin
      ol_mem[ol_wa] <= ol_wd;
    end
    ol_d <= ol_mem[ol_addr];
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[q_wa] <= q_wd;
    end
    q_d <= q_mem[q_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_ROW;
      cnt          <= '0;
      row          <= '0;
      row_ins      <= 1'b0;
      emit_after   <= 1'b0;
      cursor       <= '0;
      ins_len      <= '0;
      used         <= SW'(1);
      built        <= 1'b0;
      scan_state   <= '0;
      pos          <= '0;
      head         <= '0;
      tail         <= '0;
      n_q          <= '0;
      st_q         <= STS_OK;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready && !res_load) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (item_valid) begin
            b_q   <= data_byte;
            idx_q <= pattern_index;
            end_q <= pattern_end;
            st_q  <= STS_OK;
            case (action)
              ACT_CLEAR: begin
                used       <= SW'(1);
                cursor     <= '0;
                ins_len    <= '0;
                built      <= 1'b0;
                scan_state <= '0;
                pos        <= '0;
                row        <= '0;
                cnt        <= '0;
                row_ins    <= 1'b0;
                emit_after <= 1'b1;
                state      <= ST_ROW;
              end
              ACT_INSERT: begin
                if (built) begin
                  st_q  <= STS_PHASE;
                  state <= ST_DONE;
                end else if (ins_len == REJECTED ||
                             ins_len >= 7'(MAX_PATTERN_LEN)) begin
                  st_q <= (ins_len == REJECTED) ? STS_NO_STATES : STS_TOO_LONG;
                  if (pattern_end) begin
                    cursor  <= '0;
                    ins_len <= '0;
                  end
                  state <= ST_DONE;
                end else begin
                  state <= ST_I_RD;
                end
              end
              ACT_BUILD: begin
                if (built) begin
                  st_q  <= STS_PHASE;
                  state <= ST_DONE;
                end else begin
                  cnt   <= '0;
                  head  <= '0;
                  tail  <= '0;
                  state <= ST_B_ROOT_RD;
                end
              end
              ACT_RESTART: begin
                scan_state <= '0;
                pos        <= '0;
                state      <= ST_DONE;
              end
              ACT_SCAN: begin
                if (built) begin
                  state <= ST_S_G;
                end else begin
                  st_q  <= STS_PHASE;
                  state <= ST_DONE;
                end
              end
              default: begin
                st_q  <= STS_PHASE;
                state <= ST_DONE;
              end
            endcase
          end
        end
        ST_ROW: begin
          cnt <= cnt + 8'd1;
          if (cnt == 8'hff) begin
            if (row_ins) begin
              state <= ST_I_LINK;
            end else if (emit_after) begin
              state <= ST_DONE;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_I_RD: state <= ST_I_CHK;
        ST_I_CHK: begin
          if (ga_d != NONE_ST) begin
            s_q   <= st_ok(ga_d);
            state <= ST_I_ADV;
          end else if (used >= NONE_ST) begin
            st_q    <= STS_NO_STATES;
            ins_len <= REJECTED;
            state   <= ST_I_END;
          end else begin
            s_q     <= used[IW-1:0];
            row     <= used[IW-1:0];
            used    <= used + SW'(1);
            cnt     <= '0;
            row_ins <= 1'b1;
            state   <= ST_ROW;
          end
        end
        ST_I_LINK: state <= ST_I_ADV;
        ST_I_ADV: begin
          cursor  <= s_q;
          ins_len <= ins_len + 7'd1;
          state   <= ST_I_END;
        end
        ST_I_END: begin
          if (end_q && st_q == STS_OK) begin
            state <= ST_I_SO;
          end else begin
            if (end_q) begin
              cursor  <= '0;
              ins_len <= '0;
            end
            state <= ST_DONE;
          end
        end
        ST_I_SO: begin
          cursor  <= '0;
          ins_len <= '0;
          state   <= ST_DONE;
        end
        ST_B_ROOT_RD: state <= ST_B_ROOT_WR;
        ST_B_ROOT_WR: begin
          if (enq) begin
            tail <= tail + SW'(1);
          end
          cnt   <= cnt + 8'd1;
          state <= (cnt == 8'hff) ? ST_B_DEQ : ST_B_ROOT_RD;
        end
        ST_B_DEQ: begin
          if (head < tail) begin
            state <= ST_B_Q;
          end else begin
            built      <= 1'b1;
            cursor     <= '0;
            ins_len    <= '0;
            scan_state <= '0;
            pos        <= '0;
            state      <= ST_DONE;
          end
        end
        ST_B_Q: begin
          s_q   <= st_ok(SW'(q_d));
          head  <= head + SW'(1);
          state <= ST_B_F;
        end
        ST_B_F: begin
          f_q   <= fl_d;
          state <= ST_B_OL;
        end
        ST_B_OL: begin
          cnt   <= '0;
          state <= ST_B_C_RD;
        end
        ST_B_C_RD: state <= ST_B_C_WR;
        ST_B_C_WR: begin
          if (enq) begin
            tail <= tail + SW'(1);
          end
          cnt   <= cnt + 8'd1;
          state <= (cnt == 8'hff) ? ST_B_DEQ : ST_B_C_RD;
        end
        ST_S_G: state <= ST_S_S;
        ST_S_S: begin
          s_q        <= st_ok(ga_d);
          scan_state <= st_ok(ga_d);
          if (pos != {POSITION_BITS{1'b1}}) begin
            pos <= pos + POSITION_BITS'(1);
          end
          state <= ST_S_O;
        end
        ST_S_O: begin
          n_q <= '0;
          if (o_first < NONE_ST) begin
            o_q   <= o_first;
            state <= ST_S_RD;
          end else if (slot_free) begin
            result_valid  <= 1'b1;
            status        <= STS_OK;
            match_valid   <= 1'b0;
            match_pattern <= '0;
            match_end     <= '0;
            last_of_run   <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        ST_S_RD: state <= ST_S_M;
        ST_S_M: begin
          if (slot_free) begin
            result_valid  <= 1'b1;
            status        <= STS_OK;
            match_valid   <= 1'b1;
            match_pattern <= so_d[7:0];
            match_end     <= 32'(pos);
            last_of_run   <= m_last;
            n_q           <= n_q + 6'd1;
            o_q           <= ol_d;
            state         <= m_last ? ST_IDLE : ST_S_RD;
          end
        end
        ST_DONE: begin
          if (slot_free) begin
            result_valid  <= 1'b1;
            status        <= st_q;
            match_valid   <= 1'b0;
            match_pattern <= '0;
            match_end     <= '0;
            last_of_run   <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `MPBM_ASSERT_IMPL(a_used_range, clk, rst, 1'b1, used != '0 && used <= NONE_ST)
  `MPBM_ASSERT_IMPL(a_queue_order, clk, rst, 1'b1, head <= tail)
  `MPBM_ASSERT_IMPL(a_chain_state, clk, rst, state == ST_S_M, o_q < NONE_ST)
  `MPBM_ASSERT_NEXT(a_build_done, clk, rst, state == ST_B_DEQ && head >= tail, built)

endmodule
